### src/tsip_pkg.sv
// shared types, constants and field layout table for the packet deframer and parser
`default_nettype none
package tsip_pkg;

  localparam int BUF_BYTES = 64;
  localparam int ADDR_W = $clog2(BUF_BYTES);
  localparam int CNT_W = $clog2(BUF_BYTES + 1);
  localparam int POS_W = 6;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_ETX = 8'h03;
  localparam logic [7:0] ID_TRACK = 8'h5c;
  localparam logic [7:0] ID_SEL = 8'h6d;
  localparam logic [7:0] ID_SUPER = 8'h8f;
  localparam logic [7:0] SUBID_TIME = 8'hab;

  localparam logic [1:0] KIND_TRACK = 2'd0;
  localparam logic [1:0] KIND_SEL = 2'd1;
  localparam logic [1:0] KIND_TIME = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_LEN = 3'd1;
  localparam logic [2:0] ST_BAD_ID = 3'd2;
  localparam logic [2:0] ST_BAD_SUBID = 3'd3;
  localparam logic [2:0] ST_OVF_EMPTY = 3'd4;

  // field value transforms
  localparam logic [2:0] XF_RAW = 3'd0;
  localparam logic [2:0] XF_LOW3 = 3'd1;
  localparam logic [2:0] XF_BIT3 = 3'd2;
  localparam logic [2:0] XF_HI4 = 3'd3;
  localparam logic [2:0] XF_HI5 = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [1:0] nb_m1;
    logic [2:0] xf;
  } desc_t;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic cap_id;
    logic cap_b1;
    logic acc_clr;
    logic acc_shift;
    logic load_field;
    logic load_status;
    logic clear;
    logic [1:0] kind;
    logic [4:0] idx;
    logic [2:0] code;
    logic [2:0] xf;
  } cmd_t;

  typedef struct packed {
    logic esc_pending;
    logic etx_now;
    logic out_free;
    logic [7:0] id;
    logic [7:0] b1;
    logic [CNT_W-1:0] count;
    logic ovf;
  } stat_t;

  // byte position, length and transform of each field
  function automatic desc_t field_desc(input logic [1:0] kind, input logic [4:0] idx);
    desc_t d;
    d.pos = '0;
    d.nb_m1 = 2'd0;
    d.xf = XF_RAW;
    case (kind)
      KIND_TRACK: begin
        case (idx) inside
          5'd0: d.pos = 6'd1;
          5'd1: begin
            d.pos = 6'd2;
            d.xf = XF_LOW3;
          end
          5'd2: begin
            d.pos = 6'd2;
            d.xf = XF_HI5;
          end
          5'd3: d.pos = 6'd3;
          5'd4: d.pos = 6'd4;
          [5'd5:5'd8]: begin
            d.pos = (6'(idx) << 2) - 6'd15;
            d.nb_m1 = 2'd3;
          end
          [5'd9:5'd12]: d.pos = 6'(idx) + 6'd12;
          default: d.pos = '0;
        endcase
      end
      KIND_SEL: begin
        case (idx) inside
          5'd0: begin
            d.pos = 6'd1;
            d.xf = XF_LOW3;
          end
          5'd1: begin
            d.pos = 6'd1;
            d.xf = XF_BIT3;
          end
          5'd2: begin
            d.pos = 6'd1;
            d.xf = XF_HI4;
          end
          [5'd3:5'd6]: begin
            d.pos = (6'(idx) << 2) - 6'd10;
            d.nb_m1 = 2'd3;
          end
          default: d.pos = 6'(idx) + 6'd11;
        endcase
      end
      KIND_TIME: begin
        case (idx) inside
          5'd0: begin
            d.pos = 6'd2;
            d.nb_m1 = 2'd3;
          end
          5'd1: begin
            d.pos = 6'd6;
            d.nb_m1 = 2'd1;
          end
          5'd2: begin
            d.pos = 6'd8;
            d.nb_m1 = 2'd1;
          end
          [5'd3:5'd8]: d.pos = 6'(idx) + 6'd7;
          5'd9: begin
            d.pos = 6'd16;
            d.nb_m1 = 2'd1;
          end
          default: d.pos = '0;
        endcase
      end
      default: d.pos = '0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### src/tsip_dp.sv
// datapath: deframing registers, payload memory, field assembly and output register
`default_nettype none
module tsip_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [7:0] rx_byte,
  input  wire tsip_pkg::cmd_t cmd,
  output tsip_pkg::stat_t st,
  input  wire logic out_ready,
  output logic out_valid,
  output logic is_status,
  output logic [1:0] packet_kind,
  output logic [4:0] field_index,
  output logic [31:0] field_value,
  output logic [2:0] status_code,
  output logic last
);
  import tsip_pkg::*;

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rd_data;
  logic [CNT_W-1:0] count;
  logic esc;
  logic inside_pkt;
  logic ovf;
  logic [7:0] id;
  logic [7:0] b1;
  logic [31:0] acc;
  logic [31:0] xf_value;
  logic store;
  logic room;

  assign room = count < CNT_W'(BUF_BYTES);
  assign store = cmd.take && ((esc && rx_byte != SYM_ETX) ||
                 (!esc && inside_pkt && rx_byte != SYM_DLE));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      esc <= 1'b0;
      inside_pkt <= 1'b0;
      ovf <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      ovf <= 1'b0;
    end else if (cmd.take) begin
      if (esc) begin
        esc <= 1'b0;
        if (rx_byte == SYM_ETX) begin
          inside_pkt <= 1'b0;
        end
      end else if (inside_pkt) begin
        if (rx_byte == SYM_DLE) begin
          esc <= 1'b1;
        end
      end else if (rx_byte == SYM_DLE) begin
        inside_pkt <= 1'b1;
        count <= '0;
        ovf <= 1'b0;
      end
      if (store) begin
        if (room) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store && room) begin
      mem[count[ADDR_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_id) begin
      id <= rd_data;
    end
    if (cmd.cap_b1) begin
      b1 <= rd_data;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_shift) begin
      acc <= {acc[23:0], rd_data};
    end
  end

  always_comb begin
    case (cmd.xf)
      XF_LOW3: xf_value = {29'd0, acc[2:0]};
      XF_BIT3: xf_value = {31'd0, acc[3]};
      XF_HI4: xf_value = {28'd0, acc[7:4]};
      XF_HI5: xf_value = {27'd0, acc[7:3]};
      default: xf_value = acc;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_field || cmd.load_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_field) begin
      is_status <= 1'b0;
      packet_kind <= cmd.kind;
      field_index <= cmd.idx;
      field_value <= xf_value;
      status_code <= ST_OK;
      last <= 1'b0;
    end else if (cmd.load_status) begin
      is_status <= 1'b1;
      packet_kind <= cmd.kind;
      field_index <= '0;
      field_value <= '0;
      status_code <= cmd.code;
      last <= 1'b1;
    end
  end

  assign st.esc_pending = esc;
  assign st.etx_now = esc && (rx_byte == SYM_ETX);
  assign st.out_free = !out_valid || out_ready;
  assign st.id = id;
  assign st.b1 = b1;
  assign st.count = count;
  assign st.ovf = ovf;

endmodule
`default_nettype wire

### src/tsip_ctrl.sv
// controller: byte intake, header check and field emission sequencing
`default_nettype none
module tsip_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire tsip_pkg::stat_t st,
  output tsip_pkg::cmd_t cmd
);
  import tsip_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_H0 = 4'd1;
  localparam logic [3:0] S_H1 = 4'd2;
  localparam logic [3:0] S_H2 = 4'd3;
  localparam logic [3:0] S_CHK = 4'd4;
  localparam logic [3:0] S_FRD = 4'd5;
  localparam logic [3:0] S_FACC = 4'd6;
  localparam logic [3:0] S_FEMIT = 4'd7;
  localparam logic [3:0] S_STAT = 4'd8;

  logic [3:0] state, state_next;
  logic [1:0] kind, kind_next;
  logic [2:0] code, code_next;
  logic [4:0] nf, nf_next;
  logic [4:0] fidx, fidx_next;
  logic [1:0] bcnt, bcnt_next;
  desc_t desc;
  logic [3:0] svs;

  assign desc = field_desc(kind, fidx);
  assign svs = st.b1[7:4];
  // a packet end waits while the previous status word is still unread
  assign in_ready = (state == S_IDLE) && !(st.esc_pending && !st.out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    kind <= kind_next;
    code <= code_next;
    nf <= nf_next;
    fidx <= fidx_next;
    bcnt <= bcnt_next;
  end

  always_comb begin
    state_next = state;
    kind_next = kind;
    code_next = code;
    nf_next = nf;
    fidx_next = fidx;
    bcnt_next = bcnt;
    cmd = '0;
    cmd.kind = kind;
    cmd.idx = fidx;
    cmd.code = code;
    cmd.xf = desc.xf;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid && in_ready;
        if (cmd.take && st.etx_now) begin
          state_next = S_H0;
        end
      end
      S_H0: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = '0;
        state_next = S_H1;
      end
      S_H1: begin
        cmd.cap_id = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_addr = ADDR_W'(1);
        state_next = S_H2;
      end
      S_H2: begin
        cmd.cap_b1 = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.acc_clr = 1'b1;
        fidx_next = '0;
        bcnt_next = '0;
        nf_next = '0;
        code_next = ST_OK;
        kind_next = KIND_NONE;
        if (st.ovf || st.count == '0) begin
          code_next = ST_OVF_EMPTY;
        end else begin
          case (st.id)
            ID_TRACK: begin
              kind_next = KIND_TRACK;
              if (st.count != CNT_W'(25)) begin
                code_next = ST_BAD_LEN;
              end else begin
                nf_next = 5'd13;
              end
            end
            ID_SEL: begin
              kind_next = KIND_SEL;
              if (st.count < CNT_W'(2) || st.count != CNT_W'(18) + CNT_W'(svs)) begin
                code_next = ST_BAD_LEN;
              end else begin
                nf_next = 5'd7 + 5'(svs);
              end
            end
            ID_SUPER: begin
              if (st.count < CNT_W'(2) || st.b1 != SUBID_TIME) begin
                code_next = ST_BAD_SUBID;
              end else if (st.count != CNT_W'(18)) begin
                kind_next = KIND_TIME;
                code_next = ST_BAD_LEN;
              end else begin
                kind_next = KIND_TIME;
                nf_next = 5'd10;
              end
            end
            default: code_next = ST_BAD_ID;
          endcase
        end
        state_next = (nf_next == '0) ? S_STAT : S_FRD;
      end
      S_FRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = ADDR_W'(desc.pos) + ADDR_W'(bcnt);
        state_next = S_FACC;
      end
      S_FACC: begin
        cmd.acc_shift = 1'b1;
        if (bcnt == desc.nb_m1) begin
          state_next = S_FEMIT;
        end else begin
          bcnt_next = bcnt + 2'd1;
          state_next = S_FRD;
        end
      end
      S_FEMIT: begin
        if (st.out_free) begin
          cmd.load_field = 1'b1;
          cmd.acc_clr = 1'b1;
          bcnt_next = '0;
          if (fidx == nf - 5'd1) begin
            state_next = S_STAT;
          end else begin
            fidx_next = fidx + 5'd1;
            state_next = S_FRD;
          end
        end
      end
      S_STAT: begin
        if (st.out_free) begin
          cmd.load_status = 1'b1;
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### src/tsip_deframe_and_field_parse.sv
// top level: DLE/ETX byte deframer with field parser for three packet types
// after a packet-ending word the header bytes are fetched and the length is checked; each
//   field is then read byte by byte before its word is loaded (only a status word if none)
// throughput: one byte word per cycle within a packet, unless a byte after a DLE waits on an
//   unread status word; after a packet end, input is held off while header and payload bytes
//   are read and every field word and the status word are loaded, longer if the output stalls
// reset: control, counters and output valid clear at once; payload memory is not cleared
`default_nettype none
module tsip_deframe_and_field_parse (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [7:0] rx_byte,
  output logic out_valid,
  input  wire logic out_ready,
  output logic is_status,
  output logic [1:0] packet_kind,
  output logic [4:0] field_index,
  output logic [31:0] field_value,
  output logic [2:0] status_code,
  output logic last
);
  import tsip_pkg::*;

  cmd_t cmd;
  stat_t st;

  // sequencer: intake, header fetch, length check, byte-by-byte field fetch
  tsip_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st(st),
    .cmd(cmd)
  );

  // storage, big-endian assembly and the output register
  tsip_dp u_dp (
    .clk(clk),
    .rst(rst),
    .rx_byte(rx_byte),
    .cmd(cmd),
    .st(st),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .is_status(is_status),
    .packet_kind(packet_kind),
    .field_index(field_index),
    .field_value(field_value),
    .status_code(status_code),
    .last(last)
  );

`ifndef ASSERT_OFF
  // a packet end hands control to the decoder, so intake stops next cycle
  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && st.etx_now) |=> !in_ready)
    else $error("intake not stopped after packet end");

  // the closing status word is the only one marked last
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == is_status))
    else $error("last and status flag disagree");

  // field words carry no error code
  a_field_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_status) |-> (status_code == ST_OK))
    else $error("field word with error code");

  // the fill count never passes the buffer size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.count <= CNT_W'(BUF_BYTES))
    else $error("payload count overrun");
`endif

endmodule
`default_nettype wire
